// ----- sv/ccw_pkg.sv -----
`default_nettype none

package ccw_pkg;

    // Fixed field widths of the request, result and configuration ports.
    localparam int VALUE_W   = 14;
    localparam int COUNT_W   = 3;
    localparam int WAYS_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int COIN_REGS = 7;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_AMOUNT = 16383;
    localparam int DEF_MAX_COINS  = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_1 = 3'd1;

    localparam logic [COUNT_W-1:0] COIN_COUNT_RESET = 3'd7;

    typedef logic [VALUE_W-1:0] coin_value_t;

    localparam coin_value_t COIN_VALUE_RESET [COIN_REGS] = '{
        14'd50, 14'd100, 14'd200, 14'd500, 14'd1000, 14'd2000, 14'd5000
    };

    // One entry of the ways table: the count and a sticky overflow mark.
    typedef struct packed {
        logic              over;
        logic [WAYS_W-1:0] val;
    } entry_t;

endpackage

`default_nettype wire

// ----- sv/coin_change_way_counter.sv -----
`default_nettype none

// Coin change way counter.
//
// A request is taken when start is high and busy is low; amount is sampled
// then. The block counts the unordered combinations of the configured
// denominations that sum exactly to amount and presents the count on
// way_count and count_saturated, marked by done, high for a single cycle. A
// count that does not fit in 32 bits reads as all ones with count_saturated
// set. Amount 0 always gives 1. An amount above MAX_AMOUNT gives 0, with done
// in the cycle after it is taken. The result receiver cannot stall.
//
// The work is done in a single ways table memory by one saturating adder.
// A request first sets entries 0..amount, one per cycle, entry 0 to one and
// the rest to zero, then sweeps each usable denomination c over entries
// c..amount, one update per cycle; the memory write port sets the pace.
// Busy stays high for the whole of a request within MAX_AMOUNT; one above
// it leaves busy low.
//
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data while
// the block is idle, a rule on the user that the block does not enforce.
// Reset restores the default coin set; the table needs no clearing pass.
module coin_change_way_counter #(
    parameter int MAX_AMOUNT = ccw_pkg::DEF_MAX_AMOUNT,
    parameter int MAX_COINS  = ccw_pkg::DEF_MAX_COINS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            start,
    output      logic                            busy,
    input  wire logic [ccw_pkg::VALUE_W-1:0]     amount,
    // result channel
    output      logic                            done,
    output      logic [ccw_pkg::WAYS_W-1:0]      way_count,
    output      logic                            count_saturated,
    // configuration channel
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [ccw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccw_pkg::VALUE_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(DEPTH);
    // Width wide enough to compare amounts, coin values and table addresses.
    localparam int IW    = (AW > ccw_pkg::VALUE_W) ? AW : ccw_pkg::VALUE_W;

    localparam logic [31:0]                  MAX_AMOUNT_W = 32'(MAX_AMOUNT);
    localparam logic [ccw_pkg::COUNT_W-1:0]  USED_MAX     = ccw_pkg::COUNT_W'(MAX_COINS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_SELECT = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    // Configuration registers.
    logic [ccw_pkg::COUNT_W-1:0] coin_count_reg;
    ccw_pkg::coin_value_t        coin_value_reg [ccw_pkg::COIN_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coin_count_reg <= ccw_pkg::COIN_COUNT_RESET;
            for (int i = 0; i < ccw_pkg::COIN_REGS; i++)
            begin
                coin_value_reg[i] <= ccw_pkg::COIN_VALUE_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == ccw_pkg::REG_COIN_COUNT)
            begin
                coin_count_reg <= cfg_data[ccw_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < ccw_pkg::COIN_REGS; i++)
            begin
                if (cfg_index == ccw_pkg::REG_COIN_VALUE_1 + ccw_pkg::CFG_IDX_W'(i))
                begin
                    coin_value_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Sequencer and datapath registers.
    logic [2:0]                  state_reg,   state_next;
    logic [AW-1:0]               top_reg,     top_next;
    logic [AW-1:0]               ptr_reg,     ptr_next;
    logic [AW-1:0]               coin_reg,    coin_next;
    logic [ccw_pkg::COUNT_W-1:0] k_reg,       k_next;
    logic                        pend_reg,    pend_next;
    logic [AW-1:0]               pa_reg,      pa_next;
    logic [AW-1:0]               pb_reg,      pb_next;
    logic                        lw_valid_reg;
    logic [AW-1:0]               lw_addr_reg;
    ccw_pkg::entry_t             lw_data_reg;
    logic                        done_reg,    done_next;
    logic [ccw_pkg::WAYS_W-1:0]  way_reg,     way_next;
    logic                        sat_reg,     sat_next;

    // Table ports.
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    ccw_pkg::entry_t wr_data;
    logic [AW-1:0]   rd_a_addr;
    logic [AW-1:0]   rd_b_addr;
    ccw_pkg::entry_t rd_a_data;
    ccw_pkg::entry_t rd_b_data;
    ccw_pkg::entry_t x_eff;
    ccw_pkg::entry_t y_eff;
    ccw_pkg::entry_t sum;

    ccw_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // A read issued in the same cycle as a write to the same entry returns
    // the old contents, so the most recent write is forwarded.
    assign x_eff = (lw_valid_reg && lw_addr_reg == pa_reg) ? lw_data_reg : rd_a_data;
    assign y_eff = (lw_valid_reg && lw_addr_reg == pb_reg) ? lw_data_reg : rd_b_data;

    ccw_sat_add u_add (
        .x   (x_eff),
        .y   (y_eff),
        .sum (sum)
    );

    // Number of coin registers in use and the coin under consideration.
    logic [ccw_pkg::COUNT_W-1:0] used;
    ccw_pkg::coin_value_t        coin_sel;
    logic [IW-1:0]               coin_ext;
    logic [IW-1:0]               top_ext;
    logic                        coin_skip;

    assign used      = (coin_count_reg > USED_MAX) ? USED_MAX : coin_count_reg;
    assign coin_sel  = coin_value_reg[k_reg];
    assign coin_ext  = IW'(coin_sel);
    assign top_ext   = IW'(top_reg);
    assign coin_skip = (coin_sel == '0) || (coin_ext > top_ext);

    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        ptr_next   = ptr_reg;
        coin_next  = coin_reg;
        k_next     = k_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        way_next   = way_reg;
        sat_next   = sat_reg;
        wr_en      = 1'b0;
        wr_addr    = pa_reg;
        wr_data    = sum;
        rd_a_addr  = ptr_reg;
        rd_b_addr  = AW'(ptr_reg - coin_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (32'(amount) > MAX_AMOUNT_W)
                    begin
                        done_next = 1'b1;
                        way_next  = '0;
                        sat_next  = 1'b0;
                    end
                    else
                    begin
                        top_next   = AW'(amount);
                        ptr_next   = '0;
                        k_next     = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Entry 0 starts at one, every other entry at zero.
                wr_en        = 1'b1;
                wr_addr      = ptr_reg;
                wr_data.over = 1'b0;
                wr_data.val  = (ptr_reg == '0) ? ccw_pkg::WAYS_W'(1) : '0;
                if (ptr_reg == top_reg)
                begin
                    state_next = ST_SELECT;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_SELECT:
            begin
                if (k_reg >= used)
                begin
                    rd_a_addr  = top_reg;
                    state_next = ST_RESULT;
                end
                else if (coin_skip)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    coin_next  = AW'(coin_sel);
                    ptr_next   = AW'(coin_sel);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Issue entry ptr while the previous one is added and written.
                pend_next = 1'b1;
                wr_en     = pend_reg;
                if (ptr_reg == top_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                wr_en      = pend_reg;
                k_next     = k_reg + 1'b1;
                state_next = ST_SELECT;
            end
            ST_RESULT:
            begin
                done_next  = 1'b1;
                way_next   = x_eff.val;
                sat_next   = x_eff.over;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        pa_next = rd_a_addr;
        pb_next = rd_b_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            lw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            lw_valid_reg <= wr_en;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        ptr_reg     <= ptr_next;
        coin_reg    <= coin_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
        way_reg     <= way_next;
        sat_reg     <= sat_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign way_count       = way_reg;
    assign count_saturated = sat_reg;

    // The result is shown only once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the sequencer is busy");

    // A saturated count always reads as all ones.
    a_sat_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (done && count_saturated) |-> (way_count == {ccw_pkg::WAYS_W{1'b1}}))
        else $error("saturated count is not all ones");

    // No table write lands beyond the requested amount.
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr <= top_reg))
        else $error("table write beyond the requested amount");

    // The sweep of a coin never reads below entry zero.
    a_run_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (ptr_reg >= coin_reg && coin_reg != '0))
        else $error("sweep address below the coin value");

    // An accepted request either starts work or returns at once.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request was dropped");

endmodule

`default_nettype wire

// ----- sv/ccw_sat_add.sv -----
`default_nettype none

// Saturating adder for ways table entries; an overflow mark is sticky.
module ccw_sat_add (
    input  wire ccw_pkg::entry_t x,
    input  wire ccw_pkg::entry_t y,
    output      ccw_pkg::entry_t sum
);

    logic [ccw_pkg::WAYS_W:0] raw;
    logic                     over;

    assign raw  = {1'b0, x.val} + {1'b0, y.val};
    assign over = x.over | y.over | raw[ccw_pkg::WAYS_W];

    assign sum.over = over;
    assign sum.val  = over ? {ccw_pkg::WAYS_W{1'b1}} : raw[ccw_pkg::WAYS_W-1:0];

endmodule

`default_nettype wire

// ----- sv/ccw_table.sv -----
`default_nettype none

// Ways table: one write port and two registered read ports.
module ccw_table #(
    parameter int DEPTH = ccw_pkg::DEF_MAX_AMOUNT + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ccw_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]   rd_a_addr,
    input  wire logic [AW-1:0]   rd_b_addr,
    output      ccw_pkg::entry_t rd_a_data,
    output      ccw_pkg::entry_t rd_b_data
);

    ccw_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the coin change way counter.
//
// Requests carry one amount each. The block answers every request with one
// result: the number of unordered combinations of the configured coins that
// sum to the amount, saturated at all ones with a flag. A scoreboard object
// keeps its own copy of the coin registers and of the ways table. It works
// out the expected result for each request at the moment the block takes it,
// and it compares the results in order as they come out.
module tb;
    import ccw_pkg::*;

    // A request that sees no handshake on any channel before the quiet counter
    // reaches this limit is taken as a hang. The limit sits well above the
    // slowest correct request, at the largest amount with all seven coins.
    localparam int QUIET_LIMIT = 400000;

    typedef struct {
        logic [WAYS_W-1:0] way_count;
        logic              saturated;
    } way_result_t;

    // Predicts the way counts and checks them against what the block returns.
    class ways_tally;
        logic [COUNT_W-1:0] coin_count;
        coin_value_t        coin_value [COIN_REGS];
        logic [WAYS_W-1:0]  ways_val [DEF_MAX_AMOUNT + 1];
        bit                 ways_over [DEF_MAX_AMOUNT + 1];
        way_result_t        pending_counts [$];
        int unsigned        fail_count;
        int unsigned        request_count;
        int unsigned        saturated_count;

        function new();
            coin_count = COIN_COUNT_RESET;
            foreach (coin_value[k]) coin_value[k] = COIN_VALUE_RESET[k];
            foreach (ways_val[a])
            begin
                ways_val[a]  = '0;
                ways_over[a] = 1'b0;
            end
            fail_count      = 0;
            request_count   = 0;
            saturated_count = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, coin_value_t data);
            if (index == REG_COIN_COUNT)
                coin_count = data[COUNT_W-1:0];
            else
                coin_value[int'(index) - int'(REG_COIN_VALUE_1)] = data;
        endfunction

        // The amount port cannot exceed the table, so every amount is counted.
        function way_result_t count_ways(logic [VALUE_W-1:0] amt);
            way_result_t r;
            int          top;
            int          c;
            logic [32:0] s;
            bit          over;
            top = int'(amt);
            ways_val[0]  = 1;
            ways_over[0] = 1'b0;
            for (int a = 1; a <= top; a++)
            begin
                ways_val[a]  = '0;
                ways_over[a] = 1'b0;
            end
            for (int k = 0; k < int'(coin_count); k++)
            begin
                c = int'(coin_value[k]);
                if (c == 0 || c > top)
                    continue;
                for (int a = c; a <= top; a++)
                begin
                    s    = {1'b0, ways_val[a]} + {1'b0, ways_val[a - c]};
                    over = ways_over[a] || ways_over[a - c] || s[WAYS_W];
                    ways_over[a] = over;
                    ways_val[a]  = over ? '1 : s[WAYS_W-1:0];
                end
            end
            r.saturated = ways_over[top];
            r.way_count = ways_over[top] ? '1 : ways_val[top];
            return r;
        endfunction

        function void note_request(logic [VALUE_W-1:0] amt);
            way_result_t r;
            r = count_ways(amt);
            pending_counts.push_back(r);
            request_count++;
            if (r.saturated)
                saturated_count++;
        endfunction

        function void check_result(logic [WAYS_W-1:0] wc, logic sat);
            way_result_t e;
            if (pending_counts.size() == 0)
            begin
                $error("result with no request waiting: way_count %0d", wc);
                fail_count++;
                return;
            end
            e = pending_counts.pop_front();
            if (wc !== e.way_count)
            begin
                $error("way_count: expected %0d, got %0d", e.way_count, wc);
                fail_count++;
            end
            if (sat !== e.saturated)
            begin
                $error("count_saturated: expected %0b, got %0b", e.saturated, sat);
                fail_count++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    logic [VALUE_W-1:0]   amount    = '0;
    logic                 done;
    logic [WAYS_W-1:0]    way_count;
    logic                 count_saturated;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]   cfg_data  = '0;

    ways_tally   tally = new();
    coin_value_t coin_plan [COIN_REGS];
    bit          steady     = 1'b0;
    int          big_left   = 2;
    int unsigned write_count = 0;
    int unsigned plan_count  = 0;
    int unsigned quiet_cycles = 0;

    coin_change_way_counter i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .amount          (amount),
        .done            (done),
        .way_count       (way_count),
        .count_saturated (count_saturated),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Results are checked at the rising edge that ends their cycle. The same
    // block watches for a hang: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                tally.check_result(way_count, count_saturated);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Sends one request. It is entered and left at a falling edge. Start is
    // either kept high for the next request or dropped for a gap, never both
    // in one step.
    task automatic send_amount(input logic [VALUE_W-1:0] amt);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 29)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            start  <= 1'b0;
            amount <= VALUE_W'($urandom_range(0, 16383));
            repeat (gap) @(negedge clk);
        end
        start  <= 1'b1;
        amount <= amt;
        do @(posedge clk); while (busy);
        tally.note_request(amt);
        @(negedge clk);
    endtask

    // Holds requests back until every result has come. Always steps to a
    // falling edge first so that start is not raised again in the same step.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(negedge clk);
        while (tally.pending_counts.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [VALUE_W-1:0] data);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 29)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        tally.write_register(index, data);
        write_count++;
        @(negedge clk);
    endtask

    // Loads the coin count register and all seven coin values from coin_plan.
    // Only called while the block is idle.
    task automatic apply_coin_plan(input logic [VALUE_W-1:0] count_data);
        write_register(REG_COIN_COUNT, count_data);
        for (int k = 0; k < COIN_REGS; k++)
            write_register(REG_COIN_VALUE_1 + CFG_IDX_W'(k), coin_plan[k]);
        cfg_valid <= 1'b0;
        plan_count++;
    endtask

    // Random coin sets lean toward small values so that counts grow large,
    // with some zero coins, some duplicates and some coins of any size.
    task automatic draw_coin_plan();
        int roll;
        for (int k = 0; k < COIN_REGS; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                coin_plan[k] = '0;
            else if (roll < 20)
                coin_plan[k] = VALUE_W'($urandom_range(1, 16383));
            else if (roll < 30 && k > 0)
                coin_plan[k] = coin_plan[$urandom_range(0, k - 1)];
            else
                coin_plan[k] = VALUE_W'($urandom_range(1, 40));
        end
    endtask

    // Most amounts are small to keep the run short; a couple may span the
    // whole table.
    task automatic draw_amount(output logic [VALUE_W-1:0] amt);
        int roll;
        roll = $urandom_range(99);
        if (big_left > 0 && roll < 3)
        begin
            big_left--;
            amt = VALUE_W'($urandom_range(0, 16383));
        end
        else if (roll < 18)
            amt = VALUE_W'($urandom_range(0, 2047));
        else
            amt = VALUE_W'($urandom_range(0, 255));
    endtask

    initial
    begin
        logic [VALUE_W-1:0] amt;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The coin set after reset: zero amount, amounts just below and at
        // the smallest coin, and two larger amounts.
        send_amount(14'd0);
        send_amount(14'd49);
        send_amount(14'd50);
        send_amount(14'd300);
        send_amount(14'd10000);
        wait_for_drain();

        // A single coin of value one over the whole table gives one way.
        coin_plan = '{14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7};
        apply_coin_plan(14'd1);
        send_amount(14'd16383);
        send_amount(14'd1);
        wait_for_drain();

        // Coins one through seven: small counts, and counts that saturate.
        apply_coin_plan(14'd7);
        send_amount(14'd2);
        send_amount(14'd7);
        send_amount(14'd10);
        send_amount(14'd500);
        send_amount(14'd1000);
        wait_for_drain();

        // Only the low bits of the count register matter, so this leaves no
        // coins in use: zero gives one way and anything else none.
        apply_coin_plan(14'h3FF8);
        send_amount(14'd0);
        send_amount(14'd5);
        wait_for_drain();

        // Zero coins are skipped, duplicates count as separate kinds, and a
        // coin larger than the amount adds nothing.
        coin_plan = '{14'd0, 14'd3, 14'd3, 14'd16383, 14'd1, 14'd0, 14'd2};
        apply_coin_plan(14'd7);
        send_amount(14'd6);
        send_amount(14'd12);
        send_amount(14'd100);
        wait_for_drain();

        // Random phases, each with its own coin set. The second phase runs
        // with no gaps on the request or register channels.
        for (int phase = 0; phase < 4; phase++)
        begin
            steady = (phase == 1);
            draw_coin_plan();
            case (phase)
                0: apply_coin_plan(14'd7);
                1: apply_coin_plan(14'd1);
                2: apply_coin_plan(VALUE_W'($urandom_range(1, 7)));
                default: apply_coin_plan(VALUE_W'($urandom_range(0, 16383)));
            endcase
            for (int n = 0; n < 25; n++)
            begin
                draw_amount(amt);
                send_amount(amt);
                if ($urandom_range(99) < 5)
                    wait_for_drain();
            end
            wait_for_drain();
        end
        steady = 1'b0;

        repeat (20) @(posedge clk);
        if (tally.pending_counts.size() != 0)
        begin
            $error("%0d results never arrived", tally.pending_counts.size());
            tally.fail_count++;
        end
        $display("Covered %0d requests, %0d of them saturated, with %0d coin sets",
                 tally.request_count, tally.saturated_count, plan_count);
        $display("loaded through %0d register writes.", write_count);
        if (tally.fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
